// ----- rtl/core/pid_power_regulator_assert.svh -----
// assertion macros for the pid power regulator
`ifndef PID_POWER_REGULATOR_ASSERT_SVH
`define PID_POWER_REGULATOR_ASSERT_SVH

// same-cycle implication, clocked on clk, held off during reset
`define PIDPR_ASSERT_IMPL(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("pid power regulator check failed");

// next-cycle implication, clocked on clk, held off during reset
`define PIDPR_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("pid power regulator check failed");

`endif

// ----- rtl/core/pidpr_pkg.sv -----
// shared types and constants for the pid power regulator
package pidpr_pkg;

	localparam int GAIN_W = 32;
	localparam int DRIVE_W = 15;
	localparam int TERM_W = 62;
	localparam int PROD_W = 80;
	localparam int ITERM_MAG_W = 61;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_LEVEL_W = $clog2(QUEUE_DEPTH) + 1;

	localparam logic [1:0] REG_KP = 2'd0;
	localparam logic [1:0] REG_KI = 2'd1;
	localparam logic [1:0] REG_KD = 2'd2;

	localparam logic [GAIN_W-1:0] KP_RESET = 32'd13107200;
	localparam logic [GAIN_W-1:0] KI_RESET = 32'd131;
	localparam logic [GAIN_W-1:0] KD_RESET = 32'd1310720;

	// 100 percent in q.20
	localparam logic signed [TERM_W-1:0] PCT_LIMIT = TERM_W'(104857600);
	localparam logic [DRIVE_W-1:0] DRIVE_MAX = 15'd25600;
	localparam logic [27:0] ROUND_HALF = 28'd2048;
	localparam logic [PROD_W-1:0] ITERM_LIMIT = {{(PROD_W-61){1'b0}}, 1'b1, 60'd0};

	typedef enum logic [1:0] {
		CLAMP_NONE = 2'd0,
		CLAMP_LOW  = 2'd1,
		CLAMP_HIGH = 2'd2
	} clamp_t;

endpackage

// ----- rtl/core/pid_power_regulator.sv -----
// pid power regulator top level: gain registers, front end, queue, back end
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------
//  input    | in_valid / in_ready    | setpoint, measured
//  output   | out_valid / out_ready  | drive, clamp_status
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one transfer per cycle in and out while the queue has room and the output is free;
// the front end updates error and sum per transfer, the back end multipliers pipelined
// a transfer passes the queue, back end stages s1 to s5 and the output register
// a four-entry queue lets the front end keep taking transfers while the output stalls
// reset clears the error state, the gains to their defaults and all valid flags
`include "pid_power_regulator_assert.svh"

module pid_power_regulator #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int SUM_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]       setpoint,
	input  logic signed [SAMPLE_WIDTH-1:0]       measured,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [pidpr_pkg::DRIVE_W-1:0]        drive,
	output logic [1:0]                           clamp_status,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [1:0]                           cfg_index,
	input  logic [pidpr_pkg::GAIN_W-1:0]         cfg_data
);
	import pidpr_pkg::*;

	localparam int E_W = SAMPLE_WIDTH + 1;
	localparam int D_W = SAMPLE_WIDTH + 2;
	localparam int Q_W = E_W + D_W + SUM_WIDTH;

	logic [GAIN_W-1:0]           kp_q;
	logic [GAIN_W-1:0]           ki_q;
	logic [GAIN_W-1:0]           kd_q;

	logic                        push_valid;
	logic                        push_ready;
	logic signed [E_W-1:0]       f_err;
	logic signed [D_W-1:0]       f_diff;
	logic signed [SUM_WIDTH-1:0] f_sum;
	logic [Q_W-1:0]              q_in;
	logic [Q_W-1:0]              q_out;
	logic                        pop_valid;
	logic                        pop_ready;
	logic [QUEUE_LEVEL_W-1:0]    q_level;
	clamp_t                      status;
	logic                        clamp_ok;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= KP_RESET;
			ki_q <= KI_RESET;
			kd_q <= KD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_KP: kp_q <= cfg_data;
				REG_KI: ki_q <= cfg_data;
				REG_KD: kd_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pidpr_front #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.SUM_WIDTH(SUM_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.setpoint(setpoint),
		.measured(measured),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.err(f_err),
		.diff(f_diff),
		.sum(f_sum)
	);

	assign q_in = {f_err, f_diff, f_sum};

	pidpr_queue #(
		.WIDTH(Q_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(q_in),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(q_out),
		.level(q_level)
	);

	pidpr_back #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.SUM_WIDTH(SUM_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.kp(kp_q),
		.ki(ki_q),
		.kd(kd_q),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.err(q_out[Q_W-1 -: E_W]),
		.diff(q_out[SUM_WIDTH +: D_W]),
		.sum(q_out[SUM_WIDTH-1:0]),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive(drive),
		.clamp_status(status)
	);

	assign clamp_status = status;

	// a clamped result carries the matching end of the range
	assign clamp_ok = (status == CLAMP_LOW && drive == '0)
		|| (status == CLAMP_HIGH && drive == DRIVE_MAX);

	`PIDPR_ASSERT_IMPL(a_drive_range, out_valid, drive <= DRIVE_MAX)
	`PIDPR_ASSERT_IMPL(a_clamp_drive, out_valid && status != CLAMP_NONE, clamp_ok)
	`PIDPR_ASSERT_IMPL(a_stall_full, !in_ready, q_level == QUEUE_LEVEL_W'(QUEUE_DEPTH))
	`PIDPR_ASSERT_NEXT(a_cfg_kp, cfg_valid && cfg_ready && cfg_index == REG_KP, kp_q == $past(cfg_data))

endmodule

// ----- rtl/core/pidpr_front.sv -----
// front end: error, saturating error sum and error difference per transfer
module pidpr_front #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int SUM_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]  setpoint,
	input  logic signed [SAMPLE_WIDTH-1:0]  measured,
	output logic                            push_valid,
	input  logic                            push_ready,
	output logic signed [SAMPLE_WIDTH:0]    err,
	output logic signed [SAMPLE_WIDTH+1:0]  diff,
	output logic signed [SUM_WIDTH-1:0]     sum
);
	import pidpr_pkg::*;

	localparam int E_W = SAMPLE_WIDTH + 1;
	localparam int D_W = SAMPLE_WIDTH + 2;
	localparam int X_W = ((SUM_WIDTH > E_W) ? SUM_WIDTH : E_W) + 1;
	localparam logic signed [X_W-1:0] SUM_MAX =
		{{(X_W-SUM_WIDTH+1){1'b0}}, {(SUM_WIDTH-1){1'b1}}};
	localparam logic signed [X_W-1:0] SUM_MIN =
		{{(X_W-SUM_WIDTH+1){1'b1}}, {(SUM_WIDTH-1){1'b0}}};

	logic signed [E_W-1:0]       prev_q;
	logic signed [SUM_WIDTH-1:0] sum_q;
	logic signed [E_W-1:0]       e;
	logic signed [X_W-1:0]       acc;
	logic signed [SUM_WIDTH-1:0] sum_next;
	logic                        take;

	assign e = E_W'(setpoint) - E_W'(measured);
	assign acc = X_W'(sum_q) + X_W'(e);

	always_comb begin
		if (acc > SUM_MAX) begin
			sum_next = SUM_MAX[SUM_WIDTH-1:0];
		end else if (acc < SUM_MIN) begin
			sum_next = SUM_MIN[SUM_WIDTH-1:0];
		end else begin
			sum_next = acc[SUM_WIDTH-1:0];
		end
	end

	assign take = in_valid && push_ready;
	assign in_ready = push_ready;
	assign push_valid = in_valid;
	assign err = e;
	assign diff = D_W'(e) - D_W'(prev_q);
	assign sum = sum_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			sum_q <= '0;
		end else if (take) begin
			prev_q <= e;
			sum_q <= sum_next;
		end
	end

endmodule

// ----- rtl/core/pidpr_queue.sv -----
// short queue between front end and back end
module pidpr_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push_valid,
	output logic                       push_ready,
	input  logic [WIDTH-1:0]           push_data,
	output logic                       pop_valid,
	input  logic                       pop_ready,
	output logic [WIDTH-1:0]           pop_data,
	output logic [$clog2(DEPTH):0]     level
);
	import pidpr_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [IDX_W-1:0] wr_ptr_q;
	logic [IDX_W-1:0] rd_ptr_q;
	logic [IDX_W:0]   count_q;
	logic             push;
	logic             pop;

	assign push_ready = count_q != (IDX_W+1)'(DEPTH);
	assign pop_valid = count_q != '0;
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_data = entry_q[rd_ptr_q];
	assign level = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == IDX_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == IDX_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/pidpr_back.sv -----
// back end: gain products, integral limit, sum, clamp and rounding
module pidpr_back #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int SUM_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [pidpr_pkg::GAIN_W-1:0]         kp,
	input  logic [pidpr_pkg::GAIN_W-1:0]         ki,
	input  logic [pidpr_pkg::GAIN_W-1:0]         kd,
	input  logic                                 pop_valid,
	output logic                                 pop_ready,
	input  logic signed [SAMPLE_WIDTH:0]         err,
	input  logic signed [SAMPLE_WIDTH+1:0]       diff,
	input  logic signed [SUM_WIDTH-1:0]          sum,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [pidpr_pkg::DRIVE_W-1:0]        drive,
	output pidpr_pkg::clamp_t                    clamp_status
);
	import pidpr_pkg::*;

	localparam int E_W = SAMPLE_WIDTH + 1;
	localparam int D_W = SAMPLE_WIDTH + 2;
	localparam int LO_W = SUM_WIDTH / 2;
	localparam int HI_W = SUM_WIDTH - LO_W;
	localparam int P_W = GAIN_W + SUM_WIDTH;

	logic adv;

	logic                         v_s1;
	logic signed [E_W-1:0]        e_s1;
	logic signed [D_W-1:0]        d_s1;
	logic                         neg_s1;
	logic [SUM_WIDTH-1:0]         mag_s1;

	logic                         v_s2;
	logic signed [GAIN_W+E_W:0]   pp_s2;
	logic signed [GAIN_W+D_W:0]   pd_s2;
	logic [GAIN_W+LO_W-1:0]       plo_s2;
	logic [GAIN_W+HI_W-1:0]       phi_s2;
	logic                         neg_s2;

	logic                         v_s3;
	logic [P_W-1:0]               prod_s3;
	logic signed [TERM_W-1:0]     pdsum_s3;
	logic                         neg_s3;

	logic                         v_s4;
	logic signed [TERM_W-1:0]     iterm_s4;
	logic signed [TERM_W-1:0]     pdsum_s4;

	logic                         v_s5;
	logic signed [TERM_W-1:0]     r_s5;

	logic                         out_valid_q;
	logic [DRIVE_W-1:0]           drive_q;
	clamp_t                       status_q;

	logic [PROD_W-1:0]            prod_w;
	logic [ITERM_MAG_W-1:0]       imag;
	logic signed [TERM_W-1:0]     iterm_mag;
	logic signed [TERM_W-1:0]     iterm;
	logic [27:0]                  rounded;
	logic [DRIVE_W-1:0]           drive_next;
	clamp_t                       status_next;

	assign adv = !out_valid_q || out_ready;
	assign pop_ready = adv;

	// integral limit and sign
	assign prod_w = PROD_W'(prod_s3);
	assign imag = (prod_w > ITERM_LIMIT) ? ITERM_LIMIT[ITERM_MAG_W-1:0]
		: prod_w[ITERM_MAG_W-1:0];
	assign iterm_mag = TERM_W'(imag);
	assign iterm = neg_s3 ? -iterm_mag : iterm_mag;

	// output clamp and round half up
	assign rounded = 28'(r_s5[26:0]) + ROUND_HALF;

	always_comb begin
		if (r_s5 < 0) begin
			drive_next = '0;
			status_next = CLAMP_LOW;
		end else if (r_s5 > PCT_LIMIT) begin
			drive_next = DRIVE_MAX;
			status_next = CLAMP_HIGH;
		end else begin
			drive_next = rounded[26:12];
			status_next = CLAMP_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s1 <= err;
			d_s1 <= diff;
			neg_s1 <= sum[SUM_WIDTH-1];
			mag_s1 <= sum[SUM_WIDTH-1] ? SUM_WIDTH'(-sum) : SUM_WIDTH'(sum);

			pp_s2 <= $signed({1'b0, kp}) * e_s1;
			pd_s2 <= $signed({1'b0, kd}) * d_s1;
			plo_s2 <= ki * mag_s1[LO_W-1:0];
			phi_s2 <= ki * mag_s1[SUM_WIDTH-1:LO_W];
			neg_s2 <= neg_s1;

			prod_s3 <= {phi_s2, {LO_W{1'b0}}} + P_W'(plo_s2);
			pdsum_s3 <= TERM_W'(pp_s2) + TERM_W'(pd_s2);
			neg_s3 <= neg_s2;

			iterm_s4 <= iterm;
			pdsum_s4 <= pdsum_s3;

			r_s5 <= pdsum_s4 + iterm_s4;

			drive_q <= drive_next;
			status_q <= status_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	assign out_valid = out_valid_q;
	assign drive = drive_q;
	assign clamp_status = status_q;

endmodule

// ----- test/tb_top.sv -----
// self-checking testbench for the pid power regulator: random and directed samples, gain sweeps
`timescale 1ns / 1ps

module tb_top;
	import pidpr_pkg::*;

	localparam logic [1:0] REG_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int LONG_HOLD = 300;
	localparam int TAIL_CYCLES = 8;
	localparam logic signed [33:0] SUM_HI = 34'sd2147483647;
	localparam logic signed [33:0] SUM_LO = -34'sd2147483648;

	typedef struct {
		logic signed [15:0] sp;
		logic signed [15:0] mv;
	} sample_t;

	typedef struct {
		logic [DRIVE_W-1:0] drive;
		clamp_t status;
	} regulation_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] setpoint = '0;
	logic signed [15:0] measured = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [DRIVE_W-1:0] drive;
	logic [1:0] clamp_status;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = REG_KP;
	logic [GAIN_W-1:0] cfg_data = '0;

	// controller state as the block should hold it
	logic [GAIN_W-1:0] kp_gain = KP_RESET;
	logic [GAIN_W-1:0] ki_gain = KI_RESET;
	logic [GAIN_W-1:0] kd_gain = KD_RESET;
	logic signed [16:0] prev_err = '0;
	logic signed [31:0] err_sum = '0;

	sample_t samples_pending[$];
	regulation_t drive_due[$];
	sample_t on_bus;
	int src_gap = 0;
	int sink_stall = 0;
	int hold_ticket = 0;
	int hold_seen = 0;
	bit calm = 1'b0;
	int mismatches = 0;
	int cycle_count = 0;

	pid_power_regulator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.setpoint(setpoint),
		.measured(measured),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive(drive),
		.clamp_status(clamp_status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic regulation_t predict_regulation(sample_t s);
		logic signed [16:0] err;
		logic signed [33:0] sum_next;
		logic signed [127:0] sum_w, err_w, diff_w, kp_w, kd_w, ki_term, acc;
		logic [127:0] mag, prod;
		regulation_t res;
		err = s.sp - s.mv;
		sum_next = err_sum + err;
		if (sum_next > SUM_HI)
			sum_next = SUM_HI;
		else if (sum_next < SUM_LO)
			sum_next = SUM_LO;
		err_sum = sum_next[31:0];
		sum_w = err_sum;
		mag = (sum_w < 0) ? -sum_w : sum_w;
		prod = mag * {96'd0, ki_gain};
		if (prod > 128'(ITERM_LIMIT))
			prod = 128'(ITERM_LIMIT);
		ki_term = (sum_w < 0) ? -$signed(prod) : $signed(prod);
		kp_w = {96'd0, kp_gain};
		kd_w = {96'd0, kd_gain};
		err_w = err;
		diff_w = err_w - prev_err;
		acc = kp_w * err_w + ki_term + kd_w * diff_w;
		prev_err = err;
		if (acc < 0) begin
			res.drive = '0;
			res.status = CLAMP_LOW;
		end else if (acc > PCT_LIMIT) begin
			res.drive = DRIVE_MAX;
			res.status = CLAMP_HIGH;
		end else begin
			res.drive = DRIVE_W'((acc + ROUND_HALF) >> 12);
			res.status = CLAMP_NONE;
		end
		return res;
	endfunction

	function automatic sample_t draw_sample();
		sample_t s;
		s.sp = 16'($urandom);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: s.mv = s.sp - 16'($urandom_range(0, 400)) + 16'd200;
			6, 7, 8: s.mv = 16'($urandom);
			default: begin
				s.sp = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
				s.mv = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			end
		endcase
		return s;
	endfunction

	task automatic flag_mismatch(string what, int got, int want);
		mismatches++;
		if (mismatches <= 50)
			$display("mismatch, %s at cycle %0d: got %0d, expected %0d", what, cycle_count,
				got, want);
	endtask

	// input side: predict on each transfer, then offer the next sample
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				drive_due.push_back(predict_regulation(on_bus));
			if (!in_valid || in_ready) begin
				if (src_gap > 0) begin
					src_gap--;
					in_valid <= 1'b0;
				end else if (samples_pending.size() != 0) begin
					on_bus = samples_pending.pop_front();
					setpoint <= on_bus.sp;
					measured <= on_bus.mv;
					in_valid <= 1'b1;
					if (!calm && $urandom_range(0, 4) == 0)
						src_gap = $urandom_range(1, 11);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output side: check each transfer, stall in bursts
	always @(posedge clk) begin
		regulation_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (drive_due.size() == 0) begin
					flag_mismatch("result with none pending, drive", drive, -1);
				end else begin
					want = drive_due.pop_front();
					if (drive !== want.drive)
						flag_mismatch("drive", drive, want.drive);
					if (clamp_status !== want.status)
						flag_mismatch("clamp_status", clamp_status, want.status);
				end
			end
			if (hold_seen != hold_ticket) begin
				hold_seen = hold_ticket;
				sink_stall = LONG_HOLD;
			end
			if (sink_stall > 0) begin
				sink_stall--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				sink_stall = $urandom_range(0, 10);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [GAIN_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_KP: kp_gain = val;
			REG_KI: ki_gain = val;
			REG_KD: kd_gain = val;
			default: ;
		endcase
	endtask

	task automatic tune(logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki, logic [GAIN_W-1:0] kd);
		write_reg(REG_KP, kp);
		write_reg(REG_KI, ki);
		write_reg(REG_KD, kd);
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_sample(int sp, int mv);
		sample_t s;
		s.sp = 16'(sp);
		s.mv = 16'(mv);
		@(negedge clk);
		samples_pending.push_back(s);
	endtask

	task automatic queue_random(int n);
		@(negedge clk);
		repeat (n) samples_pending.push_back(draw_sample());
	endtask

	task automatic queue_constant(int sp, int mv, int n);
		sample_t s;
		s.sp = 16'(sp);
		s.mv = 16'(mv);
		@(negedge clk);
		repeat (n) samples_pending.push_back(s);
	endtask

	// wait until every sample is taken and every result is back
	task automatic settle();
		while (samples_pending.size() != 0 || in_valid || drive_due.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset gains: zero error, largest and smallest error
		queue_sample(0, 0);
		queue_sample(32767, -32768);
		queue_sample(-32768, 32767);
		settle();

		// unit proportional gain: exactly full drive, just above, just below zero
		write_reg(REG_NONE, 32'hffff_ffff);
		tune(32'h0001_0000, '0, '0);
		queue_sample(1600, 0);
		queue_sample(1601, 0);
		queue_sample(0, 1);
		queue_sample(800, 0);
		settle();

		// rounding at the half step
		tune(32'd1, '0, '0);
		queue_sample(2048, 0);
		queue_sample(2047, 0);
		queue_sample(6144, 0);
		queue_sample(-2048, 0);
		settle();

		// integral and derivative terms alone
		tune('0, 32'h0001_0000, '0);
		queue_sample(16, 0);
		queue_sample(-32, 0);
		queue_sample(100, 0);
		settle();
		tune('0, '0, 32'h0001_0000);
		queue_sample(100, 0);
		queue_sample(100, 0);
		queue_sample(-20, 30);
		settle();

		// random phases; the first one holds the output off for a long stretch
		tune($urandom_range(0, 4096), $urandom_range(0, 3), $urandom_range(0, 2048));
		queue_random(90);
		@(negedge clk);
		hold_ticket++;
		settle();
		tune(KP_RESET, KI_RESET, KD_RESET);
		queue_random(60);
		settle();
		tune('0, '0, '0);
		queue_random(40);
		settle();
		tune('1, '1, '1);
		queue_random(40);
		settle();
		tune($urandom, $urandom, $urandom);
		queue_random(40);
		settle();

		// large errors of both signs, swinging the error sum through zero
		@(negedge clk);
		calm = 1'b1;
		tune(KP_RESET, '1, KD_RESET);
		queue_constant(32767, -32768, 20);
		settle();
		tune(KP_RESET, KI_RESET, KD_RESET);
		queue_constant(-32768, 32767, 30);
		settle();
		tune('0, 32'h2000_0000, '0);
		queue_constant(32767, -32768, 10);
		settle();
		@(negedge clk);
		calm = 1'b0;
		tune($urandom_range(0, 4096), $urandom_range(0, 3), $urandom_range(0, 2048));
		queue_random(40);
		settle();

		// closing stretch without idling
		@(negedge clk);
		calm = 1'b1;
		tune($urandom_range(0, 4096), $urandom_range(0, 3), $urandom_range(0, 2048));
		queue_random(80);
		settle();

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
